// ===== hw/rtl/frustum_cull_box_sphere_defines.svh =====
// ----------------------------------------------------------------------------
// Frustum cull assertion macros
// Shared concurrent assertion forms for the frustum culling block.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_BOX_SPHERE_DEFINES_SVH
`define FRUSTUM_CULL_BOX_SPHERE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define FCBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define FCBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Frustum cull package
// Types and constants shared by the frustum culling block.
// ----------------------------------------------------------------------------
package fcbs_pkg;

  localparam int RegCount  = 6;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int CoordW    = 16;
  localparam int RadiusW   = 15;
  localparam int ProdW     = 32;
  localparam int OffsetW   = 31;
  localparam int DistW     = 34;
  localparam int FracShift = 14;

  typedef enum logic {
    OP_BOX    = 1'b0,
    OP_SPHERE = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PLANE_LEFT   = 3'd0,
    CFG_PLANE_RIGHT  = 3'd1,
    CFG_PLANE_BOTTOM = 3'd2,
    CFG_PLANE_TOP    = 3'd3,
    CFG_PLANE_NEAR   = 3'd4,
    CFG_PLANE_FAR    = 3'd5
  } cfg_idx_e;

  typedef logic [CoordW-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  // Register packing: d in the top field, then nz, ny, nx.
  typedef struct packed {
    logic [CoordW-1:0] d;
    logic [CoordW-1:0] nz;
    logic [CoordW-1:0] ny;
    logic [CoordW-1:0] nx;
  } plane_t;

  // Load enables of the three lane stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } load_t;

endpackage

// ===== hw/rtl/frustum_cull_box_sphere.sv =====
// ----------------------------------------------------------------------------
// Frustum culling test for boxes and spheres
// Each transfer carries one axis-aligned box or one sphere, which is tested
// against the first PLANE_COUNT frustum planes held in six plane registers;
// planes beyond the sixth have no register and never reject. The block takes
// one transfer per clock cycle while the output side is not stalled, and
// passes each through four register stages: corner selection, the
// normal-by-coordinate multipliers, the signed distance sum per plane, and
// the combination of all planes into the output register. Each stage holds
// its own valid bit, so a stall on the output only stops the stages behind
// an occupied one. Plane registers may be written only while no transfer is
// in flight.
// ----------------------------------------------------------------------------
module frustum_cull_box_sphere
  import fcbs_pkg::*;
#(
  parameter int PLANE_COUNT = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic signed [15:0]  corner_lo_x_i,
  input  logic signed [15:0]  corner_lo_y_i,
  input  logic signed [15:0]  corner_lo_z_i,
  input  logic signed [15:0]  corner_hi_x_i,
  input  logic signed [15:0]  corner_hi_y_i,
  input  logic signed [15:0]  corner_hi_z_i,
  input  logic [14:0]         sphere_radius_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                visible_o
);

  // Planes without a register get no lane and can never reject.
  localparam int LaneCount = (PLANE_COUNT < RegCount) ? PLANE_COUNT : RegCount;

  plane_t planes [RegCount];
  vec3_t  lo, hi;
  load_t  load;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 rdy1, rdy2, rdy3, rdy4;
  logic                 op_q;
  logic [RadiusW-1:0]   radius_q;
  logic [LaneCount-1:0] reject;
  logic                 visible_q;

  fcbs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .planes_o    (planes)
  );

  assign lo = {corner_lo_z_i, corner_lo_y_i, corner_lo_x_i};
  assign hi = {corner_hi_z_i, corner_hi_y_i, corner_hi_x_i};

  // A stage may load when it is empty or its content moves on.
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign load = '{s1: rdy1, s2: rdy2, s3: rdy3};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      op_q     <= op_i;
      radius_q <= sphere_radius_i;
    end
    if (rdy4) begin
      visible_q <= ~|reject;
    end
  end

  for (genvar p = 0; p < LaneCount; p++) begin : g_lane
    fcbs_plane_lane u_lane (
      .clk_i       (clk_i),
      .plane_i     (planes[p]),
      .load_i      (load),
      .op_i        (op_i),
      .lo_i        (lo),
      .hi_i        (hi),
      .op_s1_i     (op_q),
      .radius_s1_i (radius_q),
      .reject_o    (reject[p])
    );
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;
  assign visible_o   = visible_q;

endmodule

// ===== hw/rtl/fcbs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Frustum cull plane registers
// Six packed plane registers written through a plain write port.
// ----------------------------------------------------------------------------
module fcbs_cfg_regs
  import fcbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output plane_t              planes_o [RegCount]
);

  plane_t regs_q [RegCount];
  plane_t regs_d [RegCount];

  always_comb begin
    regs_d = regs_q;
    if (cfg_we_i) begin
      // Indices beyond the last plane are dropped.
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PLANE_LEFT:   regs_d[CFG_PLANE_LEFT]   = plane_t'(cfg_wdata_i);
        CFG_PLANE_RIGHT:  regs_d[CFG_PLANE_RIGHT]  = plane_t'(cfg_wdata_i);
        CFG_PLANE_BOTTOM: regs_d[CFG_PLANE_BOTTOM] = plane_t'(cfg_wdata_i);
        CFG_PLANE_TOP:    regs_d[CFG_PLANE_TOP]    = plane_t'(cfg_wdata_i);
        CFG_PLANE_NEAR:   regs_d[CFG_PLANE_NEAR]   = plane_t'(cfg_wdata_i);
        CFG_PLANE_FAR:    regs_d[CFG_PLANE_FAR]    = plane_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      regs_q <= regs_d;
    end
  end

  assign planes_o = regs_q;

endmodule

// ===== hw/rtl/fcbs_plane_lane.sv =====
// ----------------------------------------------------------------------------
// Frustum cull plane lane
// Three-stage distance test of one volume against one plane: corner select,
// multiply, then sum and sign.
// ----------------------------------------------------------------------------
module fcbs_plane_lane
  import fcbs_pkg::*;
(
  input  logic               clk_i,
  input  plane_t             plane_i,
  input  load_t              load_i,
  input  logic               op_i,
  input  vec3_t              lo_i,
  input  vec3_t              hi_i,
  input  logic               op_s1_i,
  input  logic [RadiusW-1:0] radius_s1_i,
  output logic               reject_o
);

  vec3_t n;
  vec3_t coord_d, coord_q;

  logic signed [ProdW-1:0]   prod_d [3];
  logic signed [ProdW-1:0]   prod_q [3];
  logic signed [OffsetW-1:0] offset_d, offset_q;
  logic signed [DistW-1:0]   plane_dist;
  logic                      reject_q;

  assign n = {plane_i.nz, plane_i.ny, plane_i.nx};

  // A box uses the corner farthest along the normal; a sphere its centre.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      coord_d[a] = ((op_e'(op_i) == OP_BOX) && !n[a][CoordW-1]) ? hi_i[a] : lo_i[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_d[a] = $signed(n[a]) * $signed(coord_q[a]);
    end
  end

  // Offset and radius are both brought up to 14 fraction bits.
  always_comb begin
    offset_d = $signed({plane_i.d[CoordW-1], plane_i.d, {FracShift{1'b0}}});
    if (op_e'(op_s1_i) == OP_SPHERE) begin
      offset_d = offset_d + $signed({2'b00, radius_s1_i, {FracShift{1'b0}}});
    end
  end

  assign plane_dist = $signed({{(DistW-ProdW){prod_q[0][ProdW-1]}}, prod_q[0]})
                    + $signed({{(DistW-ProdW){prod_q[1][ProdW-1]}}, prod_q[1]})
                    + $signed({{(DistW-ProdW){prod_q[2][ProdW-1]}}, prod_q[2]})
                    + $signed({{(DistW-OffsetW){offset_q[OffsetW-1]}}, offset_q});

  always_ff @(posedge clk_i) begin
    if (load_i.s1) begin
      coord_q <= coord_d;
    end
    if (load_i.s2) begin
      prod_q   <= prod_d;
      offset_q <= offset_d;
    end
    if (load_i.s3) begin
      reject_q <= plane_dist[DistW-1];
    end
  end

  assign reject_o = reject_q;

endmodule

// ===== hw/rtl/fcbs_checker.sv =====
// ----------------------------------------------------------------------------
// Frustum cull port checker
// Watches the handshake ports of the frustum culling block over time.
// ----------------------------------------------------------------------------
`include "frustum_cull_box_sphere_defines.svh"

module fcbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic visible_o
);

  // A result that is not taken stays and keeps its value.
  `FCBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(visible_o), "stalled result changed or vanished")

  // With no result waiting or the sink ready, the input side never stalls.
  `FCBS_ASSERT_IMPL(a_no_false_stall, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o, "input stalled without back-pressure")

  // A transfer whose output side does not stall meanwhile reaches the output.
  `FCBS_ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_o, "result missing four cycles after transfer")

endmodule

bind frustum_cull_box_sphere fcbs_checker u_fcbs_checker (.*);

// ===== test/cull_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frustum cull checker
// Watches the plane register port and both streaming channels, keeps its own
// copy of the six planes, works out the visible flag of every accepted query
// and compares it in order with the flags that the block delivers.
// ----------------------------------------------------------------------------
module cull_check
  import fcbs_pkg::*;
#(
  parameter int PLANE_COUNT = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                op_i,
  input  logic signed [15:0]  corner_lo_x_i,
  input  logic signed [15:0]  corner_lo_y_i,
  input  logic signed [15:0]  corner_lo_z_i,
  input  logic signed [15:0]  corner_hi_x_i,
  input  logic signed [15:0]  corner_hi_y_i,
  input  logic signed [15:0]  corner_hi_z_i,
  input  logic [14:0]         sphere_radius_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                visible_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  plane_t planes_q [RegCount];
  logic   visible_q [$];
  logic   want_visible;

  // Offsets and the radius are lifted to 14 fraction bits to line up with
  // the normal-by-coordinate products; 64 bits hold every sum exactly.
  function automatic logic cull_visible(input op_e op,
                                        input logic signed [15:0] lx, ly, lz,
                                        input logic signed [15:0] hx, hy, hz,
                                        input logic [14:0] radius);
    longint lo [3];
    longint hi [3];
    longint nrm [3];
    longint plane_dist;
    plane_t p;
    logic   vis;
    lo[0] = lx; lo[1] = ly; lo[2] = lz;
    hi[0] = hx; hi[1] = hy; hi[2] = hz;
    vis = 1'b1;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      p = (i < RegCount) ? planes_q[i] : '0;
      nrm[0] = longint'($signed(p.nx));
      nrm[1] = longint'($signed(p.ny));
      nrm[2] = longint'($signed(p.nz));
      plane_dist = longint'($signed(p.d)) * (longint'(1) << FracShift);
      for (int a = 0; a < 3; a++) begin
        if (op == OP_BOX) begin
          plane_dist += nrm[a] * ((nrm[a] >= 0) ? hi[a] : lo[a]);
        end else begin
          plane_dist += nrm[a] * lo[a];
        end
      end
      if (op == OP_SPHERE) begin
        plane_dist += longint'({1'b0, radius}) * (longint'(1) << FracShift);
      end
      if (plane_dist < 0) begin
        vis = 1'b0;
      end
    end
    return vis;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) planes_q[i] = '0;
      visible_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < RegCount) begin
        planes_q[cfg_idx_i] = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (visible_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: visible flag %0b delivered, expected none", $time, visible_i);
        end else begin
          want_visible = visible_q.pop_front();
          if (visible_i !== want_visible) begin
            fail_count_o++;
            $display("%0t: visible mismatch, expected %0b, actual %0b",
                     $time, want_visible, visible_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        visible_q.push_back(cull_visible(op_e'(op_i), corner_lo_x_i, corner_lo_y_i,
                                         corner_lo_z_i, corner_hi_x_i, corner_hi_y_i,
                                         corner_hi_z_i, sphere_radius_i));
      end
      pending_o = visible_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frustum cull testbench
// Loads several plane sets, from all-zero and axis-aligned frusta to extreme
// and random encodings, and streams box and sphere queries through the block
// with random gaps on both sides. The checker beside the block predicts and
// compares every visible flag; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import fcbs_pkg::*;

  localparam int Phases       = 6;
  localparam int RandPerPhase = 320;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 8;
  localparam int GapPercent   = 19;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam logic [15:0] OneQ14 = 16'h4000;
  localparam logic [15:0] NegOneQ14 = 16'hC000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                op;
  logic signed [15:0]  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [14:0]         radius;
  logic                out_valid;
  logic                out_ready;
  logic                visible;
  int                  fail_count;
  int                  pending;
  int                  stall_cycles;
  bit                  gaps_on;
  plane_t              plane_set [RegCount];

  frustum_cull_box_sphere dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .corner_lo_x_i  (lo_x),
    .corner_lo_y_i  (lo_y),
    .corner_lo_z_i  (lo_z),
    .corner_hi_x_i  (hi_x),
    .corner_hi_y_i  (hi_y),
    .corner_hi_z_i  (hi_z),
    .sphere_radius_i(radius),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .visible_o      (visible)
  );

  cull_check u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .op_i           (op),
    .corner_lo_x_i  (lo_x),
    .corner_lo_y_i  (lo_y),
    .corner_lo_z_i  (lo_z),
    .corner_hi_x_i  (hi_x),
    .corner_hi_y_i  (hi_y),
    .corner_hi_z_i  (hi_z),
    .sphere_radius_i(radius),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .visible_i      (visible),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= GapPercent) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Holds valid and the payload until the transfer is taken.
  task automatic send_item(input op_e kind,
                           input logic [15:0] lx, ly, lz, hx, hy, hz,
                           input logic [14:0] r);
    if (gaps_on) begin
      while ($urandom_range(99) < GapPercent) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    op       <= kind;
    lo_x     <= lx;
    lo_y     <= ly;
    lo_z     <= lz;
    hi_x     <= hx;
    hi_y     <= hy;
    hi_z     <= hz;
    radius   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes the whole plane set; the spare indexes must leave it untouched.
  task automatic load_planes(input bit spares);
    settle();
    for (int i = 0; i < RegCount; i++) write_reg(cfg_idx_e'(i), plane_set[i]);
    if (spares) begin
      write_reg(CfgSpareLo, {$urandom, $urandom});
      write_reg(CfgSpareHi, {CfgDataW{1'b1}});
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] extreme_field();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic logic [15:0] near_coord();
    int v;
    v = $urandom_range(16000);
    return 16'(v - 8000);
  endfunction

  // Frustum-like planes face inwards along one axis with a slight tilt, so a
  // good share of queries near the origin pass all six.
  function automatic plane_t rand_plane(input int mode, input int idx);
    plane_t p;
    int     nrm [3];
    int     tilt;
    case (mode)
      0: p = {$urandom, $urandom};
      1: begin
        for (int a = 0; a < 3; a++) begin
          tilt = $urandom_range(4000);
          tilt = tilt - 2000;
          if (a == idx / 2) nrm[a] = (idx % 2) ? -(16384 + tilt) : (16384 + tilt);
          else nrm[a] = tilt;
        end
        p.nx = 16'(nrm[0]);
        p.ny = 16'(nrm[1]);
        p.nz = 16'(nrm[2]);
        p.d  = 16'($urandom_range(12000));
      end
      default: begin
        p.nx = extreme_field();
        p.ny = extreme_field();
        p.nz = extreme_field();
        p.d  = extreme_field();
      end
    endcase
    if ($urandom_range(99) < 10) p = '0;
    return p;
  endfunction

  task automatic send_random();
    logic [15:0] c [6];
    logic [14:0] r;
    int          w;
    if ($urandom_range(99) < 20) begin
      for (int k = 0; k < 6; k++) c[k] = 16'($urandom);
      r = 15'($urandom);
    end else begin
      for (int k = 0; k < 3; k++) begin
        c[k] = near_coord();
        w = $urandom_range(3000);
        // A few boxes come inverted, which the block must use as given.
        c[k + 3] = ($urandom_range(99) < 5) ? 16'(int'($signed(c[k])) - w)
                                            : 16'(int'($signed(c[k])) + w);
      end
      r = ($urandom_range(99) < 5) ? 15'($urandom) : 15'($urandom_range(3000));
    end
    send_item(op_e'($urandom_range(1)), c[0], c[1], c[2], c[3], c[4], c[5], r);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    op        = OP_BOX;
    lo_x      = '0;
    lo_y      = '0;
    lo_z      = '0;
    hi_x      = '0;
    hi_y      = '0;
    hi_z      = '0;
    radius    = '0;
    out_ready = 1'b0;
    gaps_on   = 1'b1;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Planes are all zero after reset, so nothing may be rejected.
    send_item(OP_BOX, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd0);
    send_item(OP_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 15'h7FFF);
    send_item(OP_SPHERE, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0, 15'd0);
    send_item(OP_SPHERE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              15'h7FFF);

    // Axis-aligned cube of half-size 4000 around the origin.
    for (int i = 0; i < RegCount; i++) begin
      plane_set[i]   = '0;
      plane_set[i].d = 16'd4000;
    end
    plane_set[CFG_PLANE_LEFT].nx   = OneQ14;
    plane_set[CFG_PLANE_RIGHT].nx  = NegOneQ14;
    plane_set[CFG_PLANE_BOTTOM].ny = OneQ14;
    plane_set[CFG_PLANE_TOP].ny    = NegOneQ14;
    plane_set[CFG_PLANE_NEAR].nz   = OneQ14;
    plane_set[CFG_PLANE_FAR].nz    = NegOneQ14;
    load_planes(1'b1);
    send_item(OP_BOX, -16'sd100, -16'sd100, -16'sd100, 16'sd100, 16'sd100, 16'sd100, 15'd0);
    send_item(OP_BOX, -16'sd9000, 16'sd0, 16'sd0, -16'sd5000, 16'sd10, 16'sd10, 15'd0);
    send_item(OP_BOX, -16'sd9000, 16'sd0, 16'sd0, -16'sd4000, 16'sd10, 16'sd10, 15'd0);
    send_item(OP_BOX, -16'sd9000, 16'sd0, 16'sd0, -16'sd4001, 16'sd10, 16'sd10, 15'd0);
    send_item(OP_BOX, 16'sd100, 16'sd100, 16'sd100, -16'sd100, -16'sd100, -16'sd100, 15'd0);
    send_item(OP_BOX, 16'sd5000, 16'sd0, 16'sd0, -16'sd5000, 16'sd0, 16'sd0, 15'd0);
    send_item(OP_SPHERE, 16'sd0, 16'sd0, 16'sd0, 16'h7FFF, 16'h8000, 16'h7FFF, 15'd0);
    send_item(OP_SPHERE, -16'sd4005, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd4);
    send_item(OP_SPHERE, -16'sd4005, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd5);
    send_item(OP_SPHERE, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'h7FFF);
    send_item(OP_SPHERE, 16'h8000, 16'h8000, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 15'd0);

    // Extreme encodings in every field of every plane.
    plane_set[CFG_PLANE_LEFT]   = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    plane_set[CFG_PLANE_RIGHT]  = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    plane_set[CFG_PLANE_BOTTOM] = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
    plane_set[CFG_PLANE_TOP]    = '0;
    plane_set[CFG_PLANE_NEAR]   = {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001};
    plane_set[CFG_PLANE_FAR]    = {CfgDataW{1'b1}};
    load_planes(1'b1);
    send_item(OP_BOX, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd0);
    send_item(OP_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 15'd0);
    send_item(OP_SPHERE, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0, 15'h7FFF);
    send_item(OP_SPHERE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 16'h0, 15'h7FFF);
    send_item(OP_SPHERE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0);

    for (int ph = 0; ph < Phases; ph++) begin
      for (int i = 0; i < RegCount; i++) plane_set[i] = rand_plane(ph % 3, i);
      load_planes(ph % 2);
      gaps_on = (ph != 3);
      for (int n = 0; n < RandPerPhase; n++) send_random();
    end
    gaps_on = 1'b1;

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
